// ===== rtl/cbbg_pkg.sv =====
// Shared types and constants of the cluster bounding box gate.
`timescale 1ns / 1ps

package cbbg_pkg;

  localparam int COORD_BITS  = 16;
  localparam int LEN_BITS    = 16;
  localparam int INDEX_BITS  = 7;
  localparam int MAX_OBJECTS = 128;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [INDEX_BITS-1:0] INDEX_TOP = INDEX_BITS'(MAX_OBJECTS - 1);

  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_X_MIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_X_MAX = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Z_MIN = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN_Z_MAX = 3'd5;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LEN_BITS-1:0]          len_t;
  typedef logic [INDEX_BITS-1:0]        index_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   frame_start;
    logic   cluster_end;
  } point_t;

  // Box of the cluster as it stands after one point.
  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
    logic   frame_start;
    logic   cluster_end;
  } box_t;

  typedef struct packed {
    len_t x_min;
    len_t x_max;
    len_t y_min;
    len_t y_max;
    len_t z_min;
    len_t z_max;
  } limits_t;

  typedef struct packed {
    logic   accepted;
    index_t object_index;
    len_t   length_x;
    len_t   length_y;
    len_t   length_z;
    coord_t corner_a_x;
    coord_t corner_a_y;
    coord_t corner_a_z;
    coord_t corner_b_x;
    coord_t corner_b_y;
    coord_t corner_b_z;
  } result_t;

endpackage

// ===== rtl/cluster_bounding_box_gate_core.sv =====
// Top level of the cluster bounding box gate: limit registers and the two stages.
`timescale 1ns / 1ps

// Points of clustered objects enter on the in_ channel, one request per point,
// with signed x, y, z and flags for the first point of a frame and the last
// point of a cluster. Only a point that closes a cluster produces a request on
// the out_ channel: the box lengths, the two corners, the pass flag and the
// object index within the frame.
// The user must write length limits through the cfg_ port only while no point is in
// flight; the block does not enforce it. Throughput is one point per cycle while
// the receiver keeps up: the min/max update and the limit check each sit between
// a pair of registers. A closing point passes the input register, the box
// register and the result register before its result is valid.
// When the receiver stalls, the result register holds; points keep flowing
// until a second closing point sits in the box register and another point
// waits in the input register behind it, then in_ready drops.
// Synchronous reset clears the pipeline valids, the open-cluster flag, the
// object count, and returns the limits to 0 and 65535.
module cluster_bounding_box_gate_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cbbg_pkg::coord_t                   in_px,
  input  cbbg_pkg::coord_t                   in_py,
  input  cbbg_pkg::coord_t                   in_pz,
  input  logic                               in_frame_start,
  input  logic                               in_cluster_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_accepted,
  output cbbg_pkg::index_t                   out_object_index,
  output cbbg_pkg::len_t                     out_length_x,
  output cbbg_pkg::len_t                     out_length_y,
  output cbbg_pkg::len_t                     out_length_z,
  output cbbg_pkg::coord_t                   out_corner_a_x,
  output cbbg_pkg::coord_t                   out_corner_a_y,
  output cbbg_pkg::coord_t                   out_corner_a_z,
  output cbbg_pkg::coord_t                   out_corner_b_x,
  output cbbg_pkg::coord_t                   out_corner_b_y,
  output cbbg_pkg::coord_t                   out_corner_b_z,
  input  logic                               cfg_we,
  input  logic [cbbg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  cbbg_pkg::len_t                     cfg_wdata
);
  import cbbg_pkg::*;

  limits_t limits_r;
  point_t  in_point;
  logic    box_valid;
  logic    box_ready;
  box_t    box;
  result_t result;
  logic signed [COORD_BITS:0] out_y_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.x_min <= '0;
      limits_r.x_max <= '1;
      limits_r.y_min <= '0;
      limits_r.y_max <= '1;
      limits_r.z_min <= '0;
      limits_r.z_max <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEN_X_MIN: limits_r.x_min <= cfg_wdata;
        REG_LEN_X_MAX: limits_r.x_max <= cfg_wdata;
        REG_LEN_Y_MIN: limits_r.y_min <= cfg_wdata;
        REG_LEN_Y_MAX: limits_r.y_max <= cfg_wdata;
        REG_LEN_Z_MIN: limits_r.z_min <= cfg_wdata;
        REG_LEN_Z_MAX: limits_r.z_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_point.x           = in_px;
  assign in_point.y           = in_py;
  assign in_point.z           = in_pz;
  assign in_point.frame_start = in_frame_start;
  assign in_point.cluster_end = in_cluster_end;

  cbbg_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_point  (in_point),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

  cbbg_gate u_gate (
    .clk       (clk),
    .rst_n     (rst_n),
    .limits    (limits_r),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_accepted     = result.accepted;
  assign out_object_index = result.object_index;
  assign out_length_x     = result.length_x;
  assign out_length_y     = result.length_y;
  assign out_length_z     = result.length_z;
  assign out_corner_a_x   = result.corner_a_x;
  assign out_corner_a_y   = result.corner_a_y;
  assign out_corner_a_z   = result.corner_a_z;
  assign out_corner_b_x   = result.corner_b_x;
  assign out_corner_b_y   = result.corner_b_y;
  assign out_corner_b_z   = result.corner_b_z;

  assign out_y_sum = $signed({out_corner_a_y[COORD_BITS-1], out_corner_a_y})
                   + $signed({out_corner_b_y[COORD_BITS-1], out_corner_b_y});

  a_reject_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_object_index == '0)
    else $error("rejected box carries a nonzero object index");

  a_corner_y_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_corner_a_y) <= $signed(out_corner_b_y))
    else $error("corner y values out of order");

  a_corner_x_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y_sum[COORD_BITS]
                   ? ($signed(out_corner_a_x) <= $signed(out_corner_b_x))
                   : ($signed(out_corner_a_x) >= $signed(out_corner_b_x))))
    else $error("corner x values do not follow the y-center sign");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/cbbg_accum.sv =====
// Point input register and running per-axis minimum and maximum.
`timescale 1ns / 1ps

module cbbg_accum (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cbbg_pkg::point_t in_point,
  output logic            box_valid,
  input  logic            box_ready,
  output cbbg_pkg::box_t  box
);
  import cbbg_pkg::*;

  logic   pt_valid_r;
  point_t pt_r;
  logic   open_r, open_nxt;
  coord_t lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  coord_t lo_x_nxt, lo_y_nxt, lo_z_nxt, hi_x_nxt, hi_y_nxt, hi_z_nxt;
  logic   box_valid_r;
  box_t   box_r;
  logic   box_free;
  logic   pt_go;
  logic   cont;

  assign box_free = !box_valid_r || box_ready;
  assign pt_go    = pt_valid_r && box_free;
  assign in_ready = !pt_valid_r || pt_go;

  // A frame start drops whatever cluster is open.
  assign cont = open_r && !pt_r.frame_start;

  always_comb begin
    if (cont) begin
      lo_x_nxt = ($signed(pt_r.x) < $signed(lo_x_r)) ? pt_r.x : lo_x_r;
      lo_y_nxt = ($signed(pt_r.y) < $signed(lo_y_r)) ? pt_r.y : lo_y_r;
      lo_z_nxt = ($signed(pt_r.z) < $signed(lo_z_r)) ? pt_r.z : lo_z_r;
      hi_x_nxt = ($signed(pt_r.x) > $signed(hi_x_r)) ? pt_r.x : hi_x_r;
      hi_y_nxt = ($signed(pt_r.y) > $signed(hi_y_r)) ? pt_r.y : hi_y_r;
      hi_z_nxt = ($signed(pt_r.z) > $signed(hi_z_r)) ? pt_r.z : hi_z_r;
    end else begin
      lo_x_nxt = pt_r.x;
      lo_y_nxt = pt_r.y;
      lo_z_nxt = pt_r.z;
      hi_x_nxt = pt_r.x;
      hi_y_nxt = pt_r.y;
      hi_z_nxt = pt_r.z;
    end
    open_nxt = !pt_r.cluster_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r  <= 1'b0;
      open_r      <= 1'b0;
      box_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pt_valid_r <= in_valid;
      end
      if (pt_go) begin
        open_r <= open_nxt;
      end
      if (box_free) begin
        box_valid_r <= pt_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pt_r <= in_point;
    end
    if (pt_go) begin
      lo_x_r <= lo_x_nxt;
      lo_y_r <= lo_y_nxt;
      lo_z_r <= lo_z_nxt;
      hi_x_r <= hi_x_nxt;
      hi_y_r <= hi_y_nxt;
      hi_z_r <= hi_z_nxt;
      box_r.lo_x <= lo_x_nxt;
      box_r.lo_y <= lo_y_nxt;
      box_r.lo_z <= lo_z_nxt;
      box_r.hi_x <= hi_x_nxt;
      box_r.hi_y <= hi_y_nxt;
      box_r.hi_z <= hi_z_nxt;
      box_r.frame_start <= pt_r.frame_start;
      box_r.cluster_end <= pt_r.cluster_end;
    end
  end

  assign box_valid = box_valid_r;
  assign box       = box_r;

endmodule

// ===== rtl/cbbg_gate.sv =====
// Box lengths, limit check, object numbering and the result register.
`timescale 1ns / 1ps

module cbbg_gate (
  input  logic              clk,
  input  logic              rst_n,
  input  cbbg_pkg::limits_t limits,
  input  logic              box_valid,
  output logic              box_ready,
  input  cbbg_pkg::box_t    box,
  output logic              out_valid,
  input  logic              out_ready,
  output cbbg_pkg::result_t result
);
  import cbbg_pkg::*;

  logic                out_valid_r;
  result_t             result_r, result_nxt;
  index_t              count_r, count_nxt;
  index_t              count_base;
  logic [COORD_BITS:0] diff_x, diff_y, diff_z;
  logic                over_x, over_y, over_z;
  logic signed [COORD_BITS:0] y_sum;
  logic                pass;
  logic                box_go;

  assign box_ready = !box.cluster_end || !out_valid_r || out_ready;
  assign box_go    = box_valid && box_ready;

  always_comb begin
    // Widen by one bit so the difference of two signed values never wraps.
    diff_x = {box.hi_x[COORD_BITS-1], box.hi_x} - {box.lo_x[COORD_BITS-1], box.lo_x};
    diff_y = {box.hi_y[COORD_BITS-1], box.hi_y} - {box.lo_y[COORD_BITS-1], box.lo_y};
    diff_z = {box.hi_z[COORD_BITS-1], box.hi_z} - {box.lo_z[COORD_BITS-1], box.lo_z};
    over_x = |diff_x[COORD_BITS:LEN_BITS];
    over_y = |diff_y[COORD_BITS:LEN_BITS];
    over_z = |diff_z[COORD_BITS:LEN_BITS];
    y_sum  = $signed({box.lo_y[COORD_BITS-1], box.lo_y})
           + $signed({box.hi_y[COORD_BITS-1], box.hi_y});

    result_nxt.length_x = over_x ? '1 : diff_x[LEN_BITS-1:0];
    result_nxt.length_y = over_y ? '1 : diff_y[LEN_BITS-1:0];
    result_nxt.length_z = over_z ? '1 : diff_z[LEN_BITS-1:0];

    pass = !over_x && !over_y && !over_z
        && (limits.x_min <= diff_x[LEN_BITS-1:0]) && (diff_x[LEN_BITS-1:0] <= limits.x_max)
        && (limits.y_min <= diff_y[LEN_BITS-1:0]) && (diff_y[LEN_BITS-1:0] <= limits.y_max)
        && (limits.z_min <= diff_z[LEN_BITS-1:0]) && (diff_z[LEN_BITS-1:0] <= limits.z_max);

    count_base = box.frame_start ? '0 : count_r;
    count_nxt  = count_base;
    if (box.cluster_end && pass && (count_base < INDEX_TOP)) begin
      count_nxt = count_base + 1'b1;
    end

    result_nxt.accepted     = pass;
    result_nxt.object_index = pass ? count_base : '0;
    if (!y_sum[COORD_BITS]) begin
      result_nxt.corner_a_x = box.hi_x;
      result_nxt.corner_b_x = box.lo_x;
    end else begin
      result_nxt.corner_a_x = box.lo_x;
      result_nxt.corner_b_x = box.hi_x;
    end
    result_nxt.corner_a_y = box.lo_y;
    result_nxt.corner_a_z = box.lo_z;
    result_nxt.corner_b_y = box.hi_y;
    result_nxt.corner_b_z = box.hi_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (box_go) begin
        count_r <= count_nxt;
      end
      if (box_go && box.cluster_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (box_go && box.cluster_end) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== tb/tb_cluster_bounding_box_gate_core.sv =====
// Self-checking testbench for the cluster bounding box gate core.
`timescale 1ns / 1ps

module tb_cluster_bounding_box_gate_core;
  import cbbg_pkg::*;

  localparam int IDLE_PCT       = 15;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_AT_POINT  = 320;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic   in_valid = 1'b0;
  logic   in_ready;
  point_t drv_pt = '0;

  logic   out_valid;
  logic   out_ready = 1'b0;
  logic   out_accepted;
  index_t out_object_index;
  len_t   out_length_x, out_length_y, out_length_z;
  coord_t out_corner_a_x, out_corner_a_y, out_corner_a_z;
  coord_t out_corner_b_x, out_corner_b_y, out_corner_b_z;

  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  len_t                    cfg_wdata = '0;

  // Points waiting to be offered, and boxes the block still owes us.
  point_t  pending_points[$];
  result_t expected_boxes[$];
  int      points_queued = 0;
  int      points_taken = 0;
  int      mismatch_count = 0;
  logic    quiet = 1'b0;

  // Shadow of the limit registers and of the running box.
  limits_t limits = '{x_min: 16'd0, x_max: 16'hFFFF, y_min: 16'd0, y_max: 16'hFFFF,
                      z_min: 16'd0, z_max: 16'hFFFF};
  coord_t  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic    box_open = 1'b0;
  index_t  obj_count = '0;

  always #1 clk = ~clk;

  cluster_bounding_box_gate_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_px            (drv_pt.x),
    .in_py            (drv_pt.y),
    .in_pz            (drv_pt.z),
    .in_frame_start   (drv_pt.frame_start),
    .in_cluster_end   (drv_pt.cluster_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_accepted     (out_accepted),
    .out_object_index (out_object_index),
    .out_length_x     (out_length_x),
    .out_length_y     (out_length_y),
    .out_length_z     (out_length_z),
    .out_corner_a_x   (out_corner_a_x),
    .out_corner_a_y   (out_corner_a_y),
    .out_corner_a_z   (out_corner_a_z),
    .out_corner_b_x   (out_corner_b_x),
    .out_corner_b_y   (out_corner_b_y),
    .out_corner_b_z   (out_corner_b_z),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Folds one accepted point into the shadow box and, on a closing point,
  // queues the box the block has to report.
  task automatic predict_box(input point_t p);
    result_t box;
    len_t    lx, ly, lz;
    logic    ok;
    if (p.frame_start) begin
      obj_count = '0;
      box_open = 1'b0;
    end
    if (!box_open) begin
      lo_x = p.x; hi_x = p.x;
      lo_y = p.y; hi_y = p.y;
      lo_z = p.z; hi_z = p.z;
      box_open = 1'b1;
    end else begin
      if (p.x < lo_x) lo_x = p.x;
      if (p.x > hi_x) hi_x = p.x;
      if (p.y < lo_y) lo_y = p.y;
      if (p.y > hi_y) hi_y = p.y;
      if (p.z < lo_z) lo_z = p.z;
      if (p.z > hi_z) hi_z = p.z;
    end
    if (p.cluster_end) begin
      box_open = 1'b0;
      // The true spread is 0..65535, so the 16-bit wrapped difference is exact.
      lx = len_t'(hi_x - lo_x);
      ly = len_t'(hi_y - lo_y);
      lz = len_t'(hi_z - lo_z);
      ok = limits.x_min <= lx && lx <= limits.x_max &&
           limits.y_min <= ly && ly <= limits.y_max &&
           limits.z_min <= lz && lz <= limits.z_max;
      box.accepted = ok;
      box.object_index = ok ? obj_count : index_t'(0);
      if (ok && obj_count != INDEX_TOP) obj_count++;
      box.length_x = lx;
      box.length_y = ly;
      box.length_z = lz;
      if (int'(lo_y) + int'(hi_y) >= 0) begin
        box.corner_a_x = hi_x;
        box.corner_b_x = lo_x;
      end else begin
        box.corner_a_x = lo_x;
        box.corner_b_x = hi_x;
      end
      box.corner_a_y = lo_y;
      box.corner_a_z = lo_z;
      box.corner_b_y = hi_y;
      box.corner_b_z = hi_z;
      expected_boxes = {expected_boxes, box};
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: offers the next pending point, idling now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_box(drv_pt);
        points_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          drv_pt <= pending_points.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result request and throttles out_ready.
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_boxes.size() == 0) begin
          $display("%0t: unexpected result, lengths %0h %0h %0h", $time,
                   out_length_x, out_length_y, out_length_z);
          mismatch_count++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("accepted", want.accepted, out_accepted);
          check_field("object_index", want.object_index, out_object_index);
          check_field("length_x", want.length_x, out_length_x);
          check_field("length_y", want.length_y, out_length_y);
          check_field("length_z", want.length_z, out_length_z);
          check_field("corner_a_x", want.corner_a_x, out_corner_a_x);
          check_field("corner_a_y", want.corner_a_y, out_corner_a_y);
          check_field("corner_a_z", want.corner_a_z, out_corner_a_z);
          check_field("corner_b_x", want.corner_b_x, out_corner_b_x);
          check_field("corner_b_y", want.corner_b_y, out_corner_b_y);
          check_field("corner_b_z", want.corner_b_z, out_corner_b_z);
        end
      end
      // One long stall mid-run so the pipeline backs up into in_ready.
      if (!hold_done && points_taken >= HOLD_AT_POINT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress on either channel", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_limit(input logic [CFG_IDX_BITS-1:0] idx, input len_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEN_X_MIN: limits.x_min = val;
      REG_LEN_X_MAX: limits.x_max = val;
      REG_LEN_Y_MIN: limits.y_min = val;
      REG_LEN_Y_MAX: limits.y_max = val;
      REG_LEN_Z_MIN: limits.z_min = val;
      REG_LEN_Z_MAX: limits.z_max = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(input len_t x_lo, input len_t x_hi, input len_t y_lo,
                            input len_t y_hi, input len_t z_lo, input len_t z_hi);
    write_limit(REG_LEN_X_MIN, x_lo);
    write_limit(REG_LEN_X_MAX, x_hi);
    write_limit(REG_LEN_Y_MIN, y_lo);
    write_limit(REG_LEN_Y_MAX, y_hi);
    write_limit(REG_LEN_Z_MIN, z_lo);
    write_limit(REG_LEN_Z_MAX, z_hi);
  endtask

  task automatic add_point(input int x, input int y, input int z,
                           input logic fs, input logic ce);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.frame_start = fs;
    p.cluster_end = ce;
    pending_points = {pending_points, p};
    points_queued++;
  endtask

  // Waits until every point is taken and every box reported, then lets the
  // pipeline settle so points without a result have left it too.
  task automatic wait_for_drain();
    while (points_taken != points_queued || expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int jitter(input int c, input int spread, input int extreme_pct);
    int v;
    if ($urandom_range(99) < extreme_pct) return $urandom_range(1) ? 32767 : -32768;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic add_cluster(input int n, input int spread, input int extreme_pct,
                             input logic fs);
    int cx, cy, cz;
    logic start;
    cx = int'(coord_t'($urandom));
    cy = int'(coord_t'($urandom));
    cz = int'(coord_t'($urandom));
    for (int k = 0; k < n; k++) begin
      // A stray frame start inside a cluster drops what was gathered so far.
      start = (k == 0) ? fs : ($urandom_range(99) < 2);
      add_point(jitter(cx, spread, extreme_pct), jitter(cy, spread, extreme_pct),
                jitter(cz, spread, extreme_pct), start, k == n - 1);
    end
  endtask

  task automatic add_random_points(input int count, input int max_len, input int max_spread,
                                   input int extreme_pct, input int fs_pct);
    int left, n;
    left = count;
    while (left > 0) begin
      n = $urandom_range(1, max_len);
      if (n > left) n = left;
      add_cluster(n, $urandom_range(0, max_spread), extreme_pct,
                  $urandom_range(99) < fs_pct);
      left -= n;
    end
  endtask

  initial begin
    int xl, yl, zl;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits: extreme coordinates, corner swap on both sides of zero,
    // frame start in the middle of a cluster, single-point clusters.
    add_point(-32768, -32768, -32768, 1'b1, 1'b1);
    add_point(32767, 32767, 32767, 1'b1, 1'b1);
    add_point(32767, 32767, 32767, 1'b1, 1'b0);
    add_point(-32768, -32768, -32768, 1'b0, 1'b1);
    add_point(100, 5, 0, 1'b0, 1'b0);
    add_point(-200, -5, 7, 1'b0, 1'b1);
    add_point(1, 2, 3, 1'b0, 1'b0);
    add_point(4, 5, 6, 1'b0, 1'b0);
    add_point(7, -8, 9, 1'b1, 1'b0);
    add_point(-7, 8, -9, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b1);
    add_point(-1, -1, -1, 1'b0, 1'b0);
    add_point(0, 0, 0, 1'b0, 1'b1);
    wait_for_drain();

    // Lengths right at the inclusive limits and just past both x limits, the y maximum
    // and the z minimum; indexes 6 and 7 do not exist and must leave the limits alone.
    set_limits(16'd10, 16'd100, 16'd0, 16'd50, 16'd5, 16'd5);
    write_limit(CFG_IDX_BITS'(6), 16'd1);
    write_limit(CFG_IDX_BITS'(7), 16'd1);
    add_point(0, 0, 0, 1'b1, 1'b0);
    add_point(10, 50, 5, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b0);
    add_point(100, -50, -5, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b0);
    add_point(101, 0, 5, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b0);
    add_point(9, 0, 5, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b0);
    add_point(50, 51, 5, 1'b0, 1'b1);
    add_point(0, 0, 0, 1'b0, 1'b0);
    add_point(50, 0, 4, 1'b0, 1'b1);
    wait_for_drain();

    // Full range on x and y, only the largest z spread passes.
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random_points(160, 8, 2000, 25, 10);
    wait_for_drain();

    // Crossed x limits: nothing may pass.
    set_limits(16'd300, 16'd200, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    add_random_points(80, 5, 300, 5, 10);
    wait_for_drain();

    // Narrow random windows so boxes pass and fail in a mix; the long
    // receiver stall falls in this phase.
    xl = $urandom_range(0, 150);
    yl = $urandom_range(0, 150);
    zl = $urandom_range(0, 150);
    set_limits(len_t'(xl), len_t'(xl + $urandom_range(0, 400)),
               len_t'(yl), len_t'(yl + $urandom_range(0, 400)),
               len_t'(zl), len_t'(zl + $urandom_range(0, 400)));
    add_random_points(200, 5, 300, 2, 8);
    wait_for_drain();

    // One long frame of tiny clusters, no idling, so the index saturates;
    // a new frame afterwards must restart the count.
    set_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    quiet <= 1'b1;
    add_cluster(1, 0, 0, 1'b1);
    add_random_points(218, 1, 20, 0, 0);
    add_cluster(2, 50, 0, 1'b1);
    wait_for_drain();
    quiet <= 1'b0;

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
